FILE: sv/rfvs_pkg.sv
// rfvs_pkg: shared types, constants and the quarter-wave sine table
// for the ramped frequency voltage source; no dependencies
package rfvs_pkg;

  // quarter-wave table size (entries 0..SINE_TABLE_DEPTH)
  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int IDX_W = $clog2(SINE_TABLE_DEPTH + 1);
  localparam logic [IDX_W-1:0] DEPTH_IDX = IDX_W'(SINE_TABLE_DEPTH);

  // fixed-point constants
  localparam logic [63:0] PI_Q30 = 64'd3373259426;
  localparam logic [30:0] INV_TWO_PI_Q32 = 31'd683565276;
  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
  localparam logic [63:0] ONE_Q30 = 64'd1073741824;

  // table angle step is pi/(2*depth), depth a power of two
  localparam int X_SH = $clog2(2 * SINE_TABLE_DEPTH);

  // reciprocals of the series divisors (2n)(2n+1), exact for numerators
  // below 2^40
  localparam int RCP_SH = 49;
  typedef logic [63:0] rcp_tab_t [1:8];
  localparam rcp_tab_t SERIES_RCP = '{
    (64'd1 << RCP_SH) / 64'd6 + 64'd1,
    (64'd1 << RCP_SH) / 64'd20 + 64'd1,
    (64'd1 << RCP_SH) / 64'd42 + 64'd1,
    (64'd1 << RCP_SH) / 64'd72 + 64'd1,
    (64'd1 << RCP_SH) / 64'd110 + 64'd1,
    (64'd1 << RCP_SH) / 64'd156 + 64'd1,
    (64'd1 << RCP_SH) / 64'd210 + 64'd1,
    (64'd1 << RCP_SH) / 64'd272 + 64'd1
  };

  // ramp fraction width and divider depth (one quotient bit per stage)
  localparam int FRAC_W = 16;
  localparam int DIV_STEPS = FRAC_W;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_AMPLITUDE    = 3'd0,
    REG_PHASE_OFFSET = 3'd1,
    REG_CONDUCTANCE  = 3'd2,
    REG_SWITCH_TIME  = 3'd3,
    REG_RAMP_TIME    = 3'd4,
    REG_EXTRA_RATE   = 3'd5,
    REG_SYSTEM_RATE  = 3'd6
  } reg_idx_t;

  // sideband carried with a beat through the front of the pipeline
  typedef struct packed {
    logic [31:0] t;
    logic        in_ramp;
    logic        after;
  } tag_t;

  typedef logic [30:0] sine_tab_t [0:SINE_TABLE_DEPTH];

  // integer taylor series for sin(pi/2 * k/depth), Q1.30, clamped
  function automatic sine_tab_t build_sine_tab();
    sine_tab_t    tab;
    logic [63:0]  x;
    logic [63:0]  x2;
    logic [63:0]  term;
    logic [63:0]  nm;
    logic [127:0] wide;
    longint       sum;
    for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
      x = (PI_Q30 * 64'(k)) >> X_SH;
      x2 = (x * x) >> 30;
      term = x;
      sum = longint'(x);
      for (int n = 1; n <= 8; n++) begin
        nm = (term * x2) >> 30;
        wide = 128'(nm) * 128'(SERIES_RCP[n]);
        term = wide[RCP_SH+63:RCP_SH];
        if ((n & 1) != 0) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) sum = 0;
      if (sum > longint'(ONE_Q30)) sum = longint'(ONE_Q30);
      tab[k] = 31'(sum);
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage

FILE: sv/rfvs_cos.sv
// rfvs_cos: two-stage cosine of a turn angle from the quarter-wave table
// depends on rfvs_pkg
module rfvs_cos import rfvs_pkg::*; (
  input  logic               clk,
  input  logic [31:0]        angle,
  output logic signed [31:0] cos_val
);

  logic [31:0]      a;
  logic [63:0]      ip;
  logic [33:0]      i_raw;
  logic [IDX_W-1:0] idx_clamp;
  logic [IDX_W-1:0] idx_next;
  logic [IDX_W-1:0] idx;
  logic             neg;
  logic [30:0]      entry;

  // nearest entry within the quadrant, mirrored on odd quadrants
  always_comb begin
    a = angle + QUARTER_TURN;
    ip = 64'(a[29:0]) * 64'(SINE_TABLE_DEPTH) + 64'(32'h2000_0000);
    i_raw = ip[63:30];
    idx_clamp = (i_raw > 34'(SINE_TABLE_DEPTH)) ? DEPTH_IDX : i_raw[IDX_W-1:0];
    idx_next = a[30] ? (DEPTH_IDX - idx_clamp) : idx_clamp;
  end

  // index stage, then table read with sign
  always_ff @(posedge clk) begin
    idx <= idx_next;
    neg <= a[31];
    cos_val <= neg ? -$signed({1'b0, entry}) : $signed({1'b0, entry});
  end

  assign entry = SINE_TAB[idx];

endmodule

FILE: sv/rfvs_div.sv
// rfvs_div: pipelined restoring divider, one quotient bit per stage,
// for the ramp fraction; depends on rfvs_pkg
module rfvs_div import rfvs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_vld,
  input  tag_t              in_tag,
  input  logic [31:0]       in_rem,
  input  logic [31:0]       divisor,
  output logic              out_vld,
  output tag_t              out_tag,
  output logic [FRAC_W-1:0] quot
);

  logic              vld   [DIV_STEPS];
  tag_t              tg    [DIV_STEPS];
  logic [31:0]       rem   [DIV_STEPS];
  logic [FRAC_W-1:0] q     [DIV_STEPS];
  logic              p_vld [DIV_STEPS];
  tag_t              p_tg  [DIV_STEPS];
  logic [31:0]       p_rem [DIV_STEPS];
  logic [FRAC_W-1:0] p_q   [DIV_STEPS];

  for (genvar s = 0; s < DIV_STEPS; s++) begin : g_step
    logic [32:0] sh;
    logic        ge;

    if (s == 0) begin : g_first
      assign p_vld[s] = in_vld;
      assign p_tg[s]  = in_tag;
      assign p_rem[s] = in_rem;
      assign p_q[s]   = '0;
    end else begin : g_rest
      assign p_vld[s] = vld[s-1];
      assign p_tg[s]  = tg[s-1];
      assign p_rem[s] = rem[s-1];
      assign p_q[s]   = q[s-1];
    end

    // shift, trial subtract, keep remainder
    assign sh = {p_rem[s], 1'b0};
    assign ge = sh >= {1'b0, divisor};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else begin
        vld[s] <= p_vld[s];
      end
      tg[s] <= p_tg[s];
      rem[s] <= ge ? 32'(sh - {1'b0, divisor}) : sh[31:0];
      q[s] <= {p_q[s][FRAC_W-2:0], ge};
    end
  end

  assign out_vld = vld[DIV_STEPS-1];
  assign out_tag = tg[DIV_STEPS-1];
  assign quot    = q[DIV_STEPS-1];

endmodule

FILE: sv/ramped_frequency_voltage_source.sv
// ramped_frequency_voltage_source: top level, config registers and
// rate, angle, voltage and current stages; depends on rfvs_pkg, rfvs_div, rfvs_cos
//
// One beat enters per cycle and busy stays low; each result appears on
// voltage/current/saturated with done high for one cycle. Its path runs
// through the 16-stage ramp divider, two table lookups and the chain of
// registered multiplies. Results come out in input order, one per input.
// Registers must be written through wr_en, wr_index and wr_data while no
// beat is in flight; the block itself does not enforce this.
module ramped_frequency_voltage_source import rfvs_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [31:0]        sim_time,
  output logic               done,
  output logic signed [31:0] voltage,
  output logic signed [31:0] current,
  output logic               saturated,
  input  logic               wr_en,
  input  logic [2:0]         wr_index,
  input  logic [31:0]        wr_data
);

  localparam int LAT = 1 + DIV_STEPS + 2 + 11;

  // configuration registers
  logic [30:0]        amplitude;
  logic signed [18:0] phase_offset;
  logic [31:0]        conductance;
  logic [31:0]        switch_time;
  logic [31:0]        ramp_time;
  logic signed [31:0] extra_rate;
  logic signed [31:0] system_rate;

  always_ff @(posedge clk) begin
    if (rst) begin
      amplitude <= '0;
      phase_offset <= '0;
      conductance <= '0;
      switch_time <= '0;
      ramp_time <= 32'd1;
      extra_rate <= '0;
      system_rate <= '0;
    end else if (wr_en) begin
      case (reg_idx_t'(wr_index))
        REG_AMPLITUDE:    amplitude <= wr_data[30:0];
        REG_PHASE_OFFSET: phase_offset <= wr_data[18:0];
        REG_CONDUCTANCE:  conductance <= wr_data;
        REG_SWITCH_TIME:  switch_time <= wr_data;
        REG_RAMP_TIME:    ramp_time <= wr_data;
        REG_EXTRA_RATE:   extra_rate <= wr_data;
        REG_SYSTEM_RATE:  system_rate <= wr_data;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // phase offset in turns, refreshed every cycle from the register
  logic signed [49:0] ph_prod;
  logic [31:0]        phase_turn;
  assign ph_prod = phase_offset * $signed({1'b0, INV_TWO_PI_Q32}) + 50'sd32768;
  always_ff @(posedge clk) begin
    phase_turn <= ph_prod[47:16];
  end

  // input stage: ramp window and offset into the ramp
  logic [32:0] ramp_end;
  logic        v0;
  tag_t        tag0;
  logic [31:0] d0;
  assign ramp_end = {1'b0, switch_time} + {1'b0, ramp_time};

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= start && !busy;
    end
    tag0.t <= sim_time;
    tag0.in_ramp <= (sim_time >= switch_time) && ({1'b0, sim_time} < ramp_end);
    tag0.after <= {1'b0, sim_time} >= ramp_end;
    d0 <= sim_time - switch_time;
  end

  // ramp fraction
  logic              vq;
  tag_t              tagq;
  logic [FRAC_W-1:0] frac;

  rfvs_div u_div (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (v0),
    .in_tag  (tag0),
    .in_rem  (d0),
    .divisor (ramp_time),
    .out_vld (vq),
    .out_tag (tagq),
    .quot    (frac)
  );

  // raised-cosine fade lookup
  logic signed [31:0] fc;
  logic               va1, va2;
  tag_t               taga1, taga2;

  rfvs_cos u_cos_fade (
    .clk     (clk),
    .angle   ({1'b0, frac, 15'b0}),
    .cos_val (fc)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      va1 <= 1'b0;
      va2 <= 1'b0;
    end else begin
      va1 <= vq;
      va2 <= va1;
    end
    taga1 <= tagq;
    taga2 <= taga1;
  end

  // fade times extra rate
  logic signed [33:0] fsum;
  logic [16:0]        fade;
  logic signed [49:0] fe_prod;
  logic               v3;
  tag_t               tag3;
  assign fsum = 34'sd1073758208 - 34'(fc);
  assign fade = fsum[31:15];

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= va2;
    end
    tag3 <= taga2;
    fe_prod <= $signed({1'b0, fade}) * extra_rate;
  end

  // angular rate for this time
  logic signed [49:0] fe_round;
  logic signed [32:0] adj;
  logic signed [32:0] rate;
  logic               v4;
  logic [31:0]        t4;
  assign fe_round = (fe_prod + 50'sd32768) >>> 16;

  always_comb begin
    if (tag3.in_ramp) begin
      adj = fe_round[32:0];
    end else if (tag3.after) begin
      adj = 33'(extra_rate);
    end else begin
      adj = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
    t4 <= tag3.t;
    rate <= 33'(system_rate) + adj;
  end

  // rate in turns per second, Q16.48
  logic signed [63:0] rt;
  logic               v5;
  logic [31:0]        t5;
  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else begin
      v5 <= v4;
    end
    t5 <= t4;
    rt <= 64'(rate * $signed({1'b0, INV_TWO_PI_Q32}));
  end

  // high and low partial products of rate times time
  logic signed [64:0] hi_prod;
  logic [63:0]        lo_prod;
  logic [39:0]        p_hi;
  logic [31:0]        p_lo;
  logic               v6;
  assign hi_prod = $signed(rt[63:32]) * $signed({1'b0, t5});
  assign lo_prod = 64'(rt[31:0]) * 64'(t5);

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else begin
      v6 <= v5;
    end
    p_hi <= hi_prod[39:0];
    p_lo <= lo_prod[63:32];
  end

  // source angle mod one turn
  logic [39:0] acc;
  logic [31:0] angle;
  logic        v7;
  assign acc = p_hi + {8'b0, p_lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else begin
      v7 <= v6;
    end
    angle <= acc[39:8] + phase_turn;
  end

  // source cosine
  logic signed [31:0] c;
  logic               vb1, vb2;

  rfvs_cos u_cos_src (
    .clk     (clk),
    .angle   (angle),
    .cos_val (c)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vb1 <= 1'b0;
      vb2 <= 1'b0;
    end else begin
      vb1 <= v7;
      vb2 <= vb1;
    end
  end

  // voltage = amplitude * cos, rounded
  logic signed [63:0] volt_prod;
  logic signed [63:0] volt_round;
  logic signed [31:0] volt;
  logic               v8, v9;
  assign volt_round = volt_prod + 64'sd536870912;

  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
      v9 <= 1'b0;
    end else begin
      v8 <= vb2;
      v9 <= v8;
    end
    volt_prod <= $signed({1'b0, amplitude}) * c;
    volt <= volt_round[61:30];
  end

  // current = voltage * conductance
  logic signed [64:0] cur_prod;
  logic signed [31:0] volt_d;
  logic               v10;
  always_ff @(posedge clk) begin
    if (rst) begin
      v10 <= 1'b0;
    end else begin
      v10 <= v9;
    end
    cur_prod <= volt * $signed({1'b0, conductance});
    volt_d <= volt;
  end

  // rounding, saturation and result beat
  logic signed [64:0] cur_sum;
  logic signed [40:0] cur_sh;
  logic               ov_hi, ov_lo;
  assign cur_sum = cur_prod + 65'sd8388608;
  assign cur_sh = cur_sum[64:24];
  assign ov_hi = cur_sh > 41'sd2147483647;
  assign ov_lo = cur_sh < -41'sd2147483648;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
      saturated <= 1'b0;
    end else begin
      done <= v10;
      saturated <= v10 && (ov_hi || ov_lo);
    end
    voltage <= volt_d;
    if (ov_hi) begin
      current <= 32'sh7fff_ffff;
    end else if (ov_lo) begin
      current <= 32'sh8000_0000;
    end else begin
      current <= cur_sh[31:0];
    end
  end

  // fixed latency from accepted beat to result
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT done)
    else $error("result missing after fixed latency");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LAT))
    else $error("result without an accepted beat");

  a_sat_clip: assert property (@(posedge clk) disable iff (rst)
    saturated |-> done && (current == 32'sh7fff_ffff || current == 32'sh8000_0000))
    else $error("saturation flag without clipped current");

endmodule
